/* hw/rtl/upd_pkg.sv */
// Shared types and constants for the URL percent decoder.
// Used by upd_front, upd_queue, upd_back and url_percent_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 12;
    localparam int MAX_RES = 4;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd255;

    typedef enum logic [1:0] {
        STOP_INPUT = 2'd0,
        STOP_DELIM = 2'd1,
        STOP_LIMIT = 2'd2,
        STOP_ZERO  = 2'd3
    } t_stop;

    // one result as it leaves the block (last_of_run is added at the back)
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_end;
        logic [LEN_W-1:0]  final_length;
        logic [1:0]        stop_reason;
    } t_res;

    // all results caused by one input item, res[0] first
    typedef struct packed {
        logic [2:0]             n;
        t_res [MAX_RES-1:0]     res;
    } t_bundle;

    // front to queue
    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_push;

endpackage

`default_nettype wire

/* hw/rtl/upd_front.sv */
// Front part: accepts input bytes, tracks escape state and builds the results
// of each byte as one bundle. Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [upd_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [upd_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                       i_is_last,
    input  wire logic                       i_q_full,
    output upd_pkg::t_push                  o_push
);
    import upd_pkg::*;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef struct packed {
        logic [LEN_W-1:0]   cnt;
        logic               stp;
        logic [1:0]         hc;
        logic [2:0]         n;
        t_res [MAX_RES-1:0] res;
    } t_work;

    function automatic logic f_is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    // letters have bit 6 set, and their low nibble plus nine gives the value
    function automatic logic [3:0] f_hex_val(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

    function automatic t_work f_data(input t_work s, input logic [7:0] v);
        t_work r;
        r = s;
        if (s.n < 3'(MAX_RES)) begin
            r.res[s.n[1:0]] = '{out_byte: v, is_end: 1'b0,
                                final_length: '0, stop_reason: '0};
            r.n = s.n + 3'd1;
        end
        r.cnt = s.cnt + 12'd1;
        return r;
    endfunction

    function automatic t_work f_end(input t_work s, input logic [1:0] why);
        t_work r;
        r = s;
        if (s.n < 3'(MAX_RES)) begin
            r.res[s.n[1:0]] = '{out_byte: CH_NUL, is_end: 1'b1,
                                final_length: s.cnt, stop_reason: why};
            r.n = s.n + 3'd1;
        end
        r.stp = 1'b1;
        r.hc  = HELD_NONE;
        return r;
    endfunction

    // a byte taken as the start of a new character
    function automatic t_work f_plain(input t_work s, input logic [7:0] c,
                                      input logic [LEN_W-1:0] lim);
        t_work r;
        r = s;
        if (c == CH_NUL) begin
            r = f_end(s, STOP_INPUT);
        end else if (c == CH_AMP || c == CH_SPACE || c == CH_CR || c == CH_LF) begin
            r = f_end(s, STOP_DELIM);
        end else if (s.cnt >= lim) begin
            r = f_end(s, STOP_LIMIT);
        end else if (c == CH_PCT) begin
            r.hc = HELD_PCT;
        end else if (c == CH_PLUS) begin
            r = f_data(s, CH_SPACE);
        end else begin
            r = f_data(s, c);
        end
        return r;
    endfunction

    logic [LEN_W-1:0] r_limit, n_limit;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_stp, n_stp;
    logic [1:0]       r_hc, n_hc;
    logic [7:0]       r_hd, n_hd;

    logic  w_accept;
    t_work w;
    logic [7:0] w_val;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w     = '{cnt: r_cnt, stp: r_stp, hc: r_hc, n: 3'd0, res: '0};
        w_val = {f_hex_val(r_hd), f_hex_val(i_in_byte)};
        if (!r_stp) begin
            case (r_hc)
                HELD_NONE: begin
                    w = f_plain(w, i_in_byte, r_limit);
                end
                HELD_PCT: begin
                    if (f_is_hex(i_in_byte)) begin
                        w.hc = HELD_DIGIT;
                    end else begin
                        w.hc = HELD_NONE;
                        w = f_data(w, CH_PCT);
                        w = f_plain(w, i_in_byte, r_limit);
                    end
                end
                HELD_DIGIT: begin
                    w.hc = HELD_NONE;
                    if (f_is_hex(i_in_byte)) begin
                        if (w_val == 8'h00) w = f_end(w, STOP_ZERO);
                        else                w = f_data(w, w_val);
                    end else begin
                        // failed escape: '%', then held digit, then this byte
                        w = f_data(w, CH_PCT);
                        w = f_plain(w, r_hd, r_limit);
                        if (!w.stp) w = f_plain(w, i_in_byte, r_limit);
                    end
                end
                default: begin
                    w.hc = HELD_NONE;
                end
            endcase
        end
        if (i_is_last) begin
            if (!w.stp) begin
                if (w.hc != HELD_NONE) begin
                    w = f_data(w, CH_PCT);
                    // a digit still held here arrived with this very byte
                    if (w.hc == HELD_DIGIT) begin
                        w.hc = HELD_NONE;
                        w = f_plain(w, i_in_byte, r_limit);
                    end
                    w.hc = HELD_NONE;
                end
                if (!w.stp) w = f_end(w, STOP_INPUT);
            end
            w.hc  = HELD_NONE;
            w.cnt = '0;
            w.stp = 1'b0;
        end
    end

    always_comb begin
        n_limit = i_cfg_we ? i_cfg_wdata : r_limit;
        n_cnt   = w_accept ? w.cnt : r_cnt;
        n_stp   = w_accept ? w.stp : r_stp;
        n_hc    = w_accept ? w.hc  : r_hc;
        n_hd    = (w_accept && !r_stp && r_hc == HELD_PCT && f_is_hex(i_in_byte))
                  ? i_in_byte : r_hd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_cnt   <= '0;
            r_stp   <= 1'b0;
            r_hc    <= HELD_NONE;
        end else begin
            r_limit <= n_limit;
            r_cnt   <= n_cnt;
            r_stp   <= n_stp;
            r_hc    <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hd <= n_hd;
    end

    assign o_push.push          = w_accept && (w.n != 3'd0);
    assign o_push.bundle.n      = w.n;
    assign o_push.bundle.res    = w.res;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_is_last) |=> (r_cnt == '0 && !r_stp && r_hc == HELD_NONE))
        else $error("state not cleared after last byte");

    a_hc_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hc != 2'd3) && !(r_stp && r_hc != HELD_NONE))
        else $error("held count inconsistent with stop flag");

endmodule

`default_nettype wire

/* hw/rtl/upd_queue.sv */
// Short bundle queue between the front and back parts, held in flops.
// Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire upd_pkg::t_push   i_push,
    input  wire logic             i_pop,
    output upd_pkg::t_bundle      o_head,
    output logic                  o_nonempty,
    output logic                  o_full
);
    import upd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign w_wr = i_push.push && !o_full;
    assign w_rd = i_pop && o_nonempty;

    always_comb begin
        n_wp    = w_wr ? ((r_wp == PTR_LAST) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp    = w_rd ? ((r_rp == PTR_LAST) ? '0 : r_rp + 1'b1) : r_rp;
        n_count = r_count;
        if (w_wr && !w_rd)      n_count = r_count + 1'b1;
        else if (w_rd && !w_wr) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_push.bundle;
    end

    assign o_head     = r_mem[r_rp];
    assign o_nonempty = (r_count != '0);
    assign o_full     = (r_count == CNT_FULL);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.push && o_full))
        else $error("transfer pushed into a full queue");

    a_bundle_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (i_push.bundle.n != 3'd0 && i_push.bundle.n <= 3'(MAX_RES)))
        else $error("bundle with bad result count");

endmodule

`default_nettype wire

/* hw/rtl/upd_back.sv */
// Back part: walks the results of the bundle at the queue head and drives
// the output register one result per transfer. Depends on upd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire upd_pkg::t_bundle  i_head,
    input  wire logic              i_nonempty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output upd_pkg::t_res          o_res,
    output logic                   o_last
);
    import upd_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    t_res       r_res, n_res;
    logic       r_last, n_last;
    logic       w_load, w_idx_last;

    assign w_load     = i_nonempty && (!r_ovalid || i_out_ready);
    assign w_idx_last = ({1'b0, r_idx} == (i_head.n - 3'd1));
    assign o_pop      = w_load && w_idx_last;

    always_comb begin
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_out_ready;
        n_res    = r_res;
        n_last   = r_last;
        if (w_load) begin
            n_ovalid = 1'b1;
            n_res    = i_head.res[r_idx];
            n_last   = w_idx_last;
            n_idx    = w_idx_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_last <= n_last;
    end

    assign o_out_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_last      = r_last;

    // nothing follows an end result within the same input byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.is_end) |-> r_last)
        else $error("end result not last of its run");

    a_idx_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("result index not rewound after pop");

endmodule

`default_nettype wire

/* hw/rtl/url_percent_decoder_unit.sv */
// URL percent decoder: one input byte per cycle while o_in_ready is high, results
// one per cycle while i_out_ready is high, by way of the queue and output register.
// Throughput: one byte per cycle while bytes give at most one result; a byte that
//   gives k results (up to 4, e.g. a failed escape) holds the output port for all k.
// Reset: i_rst_n synchronous, active low; clears decode state and queue, limit = 255.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [upd_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [upd_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic                       i_is_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [upd_pkg::BYTE_W-1:0]      o_out_byte,
    output logic                            o_is_end,
    output logic [upd_pkg::LEN_W-1:0]       o_final_length,
    output logic [1:0]                      o_stop_reason,
    output logic                            o_last_of_run
);
    import upd_pkg::*;

    t_push   w_push;
    t_bundle w_head;
    logic    w_nonempty, w_full, w_pop;
    t_res    w_res;

    upd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_is_last   (i_is_last),
        .i_q_full    (w_full),
        .o_push      (w_push)
    );

    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_nonempty),
        .o_full     (w_full)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_nonempty  (w_nonempty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res),
        .o_last      (o_last_of_run)
    );

    assign o_out_byte     = w_res.out_byte;
    assign o_is_end       = w_res.is_end;
    assign o_final_length = w_res.final_length;
    assign o_stop_reason  = w_res.stop_reason;

endmodule

`default_nettype wire
